// ===== src/drs_pkg.sv =====
// shared types and constants for the delimited record splitter
// no dependencies; used by the top level and the port checker

package drs_pkg;

	localparam int MAX_DELIM_LEN = 8;
	localparam int SEEN_W = $clog2(MAX_DELIM_LEN + 1);
	localparam int AGE_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;
	localparam int DLEN_W = 4;
	localparam int LEN_W = 16;
	localparam int LOST_W = 32;
	localparam int DATA_W = 64;
	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELIMITER = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DELIM_LEN = 2'd2;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;
	localparam logic [DATA_W-1:0] DELIMITER_RESET = 64'd10;
	localparam logic [DLEN_W-1:0] DELIM_LEN_RESET = 4'd1;

	typedef struct packed {
		logic [7:0] byte_out;
		logic stored;
		logic [LEN_W-1:0] stored_count;
		logic [LOST_W-1:0] lost_count;
		logic delimiter_found;
		logic end_seen;
		logic record_done;
	} result_t;

endpackage

// ===== src/delimited_record_splitter_top.sv =====
// delimited record splitter: an accepted request goes to the result register,
// or to the skid on an output stall; one item per cycle while in_ready is high;
// window match and count update: combinational, record state to result register
// a two-entry output (result register plus skid) keeps in_ready registered
// async reset: config returns to max_len 256, delimiter newline, length 1;
// record state and output queue clear
// depends on drs_pkg

module delimited_record_splitter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [drs_pkg::PADDR_W-1:0]       paddr,
	input  logic [drs_pkg::DATA_W-1:0]        pwdata,
	output logic [drs_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              is_eof,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        byte_out,
	output logic                              stored,
	output logic [drs_pkg::LEN_W-1:0]         stored_count,
	output logic [drs_pkg::LOST_W-1:0]        lost_count,
	output logic                              delimiter_found,
	output logic                              end_seen,
	output logic                              record_done
);

	logic [drs_pkg::LEN_W-1:0]     max_len_q;
	logic [drs_pkg::DATA_W-1:0]    delim_q;
	logic [drs_pkg::DLEN_W-1:0]    dlen_q;
	logic [drs_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	logic [7:0]                    win_q [drs_pkg::MAX_DELIM_LEN];
	logic [7:0]                    win_nxt [drs_pkg::MAX_DELIM_LEN];
	logic [drs_pkg::SEEN_W-1:0]    seen_q;
	logic [drs_pkg::SEEN_W-1:0]    seen_nxt;
	logic [drs_pkg::LEN_W-1:0]     rec_len_q;
	logic [drs_pkg::LOST_W-1:0]    lost_q;

	logic [drs_pkg::LEN_W-1:0]     limit;
	logic [drs_pkg::SEEN_W-1:0]    act_len;
	logic                          keep;
	logic [drs_pkg::LEN_W-1:0]     rec_len_nxt;
	logic [drs_pkg::LOST_W-1:0]    lost_nxt;
	logic                          found;
	logic                          accept;
	drs_pkg::result_t              res;

	drs_pkg::result_t              out_q;
	drs_pkg::result_t              skid_q;
	logic                          out_v_q;
	logic                          skid_v_q;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[drs_pkg::PADDR_W-1:3];
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= drs_pkg::MAX_LEN_RESET;
			delim_q <= drs_pkg::DELIMITER_RESET;
			dlen_q <= drs_pkg::DELIM_LEN_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				drs_pkg::REG_MAX_LEN:   max_len_q <= pwdata[drs_pkg::LEN_W-1:0];
				drs_pkg::REG_DELIMITER: delim_q <= pwdata;
				drs_pkg::REG_DELIM_LEN: dlen_q <= pwdata[drs_pkg::DLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			drs_pkg::REG_MAX_LEN:
				prdata = {{(drs_pkg::DATA_W-drs_pkg::LEN_W){1'b0}}, max_len_q};
			drs_pkg::REG_DELIMITER:
				prdata = delim_q;
			drs_pkg::REG_DELIM_LEN:
				prdata = {{(drs_pkg::DATA_W-drs_pkg::DLEN_W){1'b0}}, dlen_q};
			default:
				prdata = '0;
		endcase
	end

	// per-item datapath
	assign limit = (max_len_q < drs_pkg::LEN_W'(2)) ? drs_pkg::LEN_W'(1)
		: max_len_q - drs_pkg::LEN_W'(1);

	always_comb begin
		if (dlen_q == '0)
			act_len = drs_pkg::SEEN_W'(1);
		else if (dlen_q > drs_pkg::DLEN_W'(drs_pkg::MAX_DELIM_LEN))
			act_len = drs_pkg::SEEN_W'(drs_pkg::MAX_DELIM_LEN);
		else
			act_len = drs_pkg::SEEN_W'(dlen_q);
	end

	always_comb begin
		win_nxt[0] = data_byte;
		for (int i = 1; i < drs_pkg::MAX_DELIM_LEN; i++)
			win_nxt[i] = win_q[i-1];
	end

	assign seen_nxt = (seen_q < drs_pkg::SEEN_W'(drs_pkg::MAX_DELIM_LEN))
		? seen_q + drs_pkg::SEEN_W'(1) : seen_q;

	assign keep = rec_len_q < limit;
	assign rec_len_nxt = keep ? rec_len_q + drs_pkg::LEN_W'(1) : rec_len_q;
	assign lost_nxt = (!keep && lost_q != '1) ? lost_q + drs_pkg::LOST_W'(1) : lost_q;

	// delimiter char k sits at window age len-1-k
	always_comb begin
		logic [drs_pkg::AGE_W-1:0] age;
		found = (seen_nxt >= act_len);
		for (int k = 0; k < drs_pkg::MAX_DELIM_LEN; k++) begin
			age = drs_pkg::AGE_W'(act_len - drs_pkg::SEEN_W'(k + 1));
			if (drs_pkg::SEEN_W'(k) < act_len && win_nxt[age] != delim_q[8*k +: 8])
				found = 1'b0;
		end
	end

	always_comb begin
		if (is_eof) begin
			res.byte_out = '0;
			res.stored = 1'b0;
			res.stored_count = rec_len_q;
			res.lost_count = lost_q;
			res.delimiter_found = 1'b0;
			res.end_seen = 1'b1;
			res.record_done = 1'b1;
		end else begin
			res.byte_out = data_byte;
			res.stored = keep;
			res.stored_count = rec_len_nxt;
			res.lost_count = lost_nxt;
			res.delimiter_found = found;
			res.end_seen = 1'b0;
			res.record_done = found;
		end
	end

	assign in_ready = !skid_v_q;
	assign accept = in_valid && in_ready;

	// record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < drs_pkg::MAX_DELIM_LEN; i++)
				win_q[i] <= '0;
			seen_q <= '0;
			rec_len_q <= '0;
			lost_q <= '0;
		end else if (accept) begin
			if (is_eof || found) begin
				for (int i = 0; i < drs_pkg::MAX_DELIM_LEN; i++)
					win_q[i] <= '0;
				seen_q <= '0;
				rec_len_q <= '0;
				lost_q <= '0;
			end else begin
				win_q <= win_nxt;
				seen_q <= seen_nxt;
				rec_len_q <= rec_len_nxt;
				lost_q <= lost_nxt;
			end
		end
	end

	// result register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_ready) begin
			out_v_q <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (!out_v_q) begin
			out_v_q <= accept;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_ready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res;
		end else if (!out_v_q) begin
			if (accept)
				out_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign byte_out = out_q.byte_out;
	assign stored = out_q.stored;
	assign stored_count = out_q.stored_count;
	assign lost_count = out_q.lost_count;
	assign delimiter_found = out_q.delimiter_found;
	assign end_seen = out_q.end_seen;
	assign record_done = out_q.record_done;

endmodule

// ===== src/drs_checker.sv =====
// port-level checks for the delimited record splitter, bound to the top level
// depends on drs_pkg and delimited_record_splitter_top

module drs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [7:0]                        byte_out,
	input  logic                              stored,
	input  logic [drs_pkg::LEN_W-1:0]         stored_count,
	input  logic [drs_pkg::LOST_W-1:0]        lost_count,
	input  logic                              delimiter_found,
	input  logic                              end_seen,
	input  logic                              record_done
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out)
			&& $stable(stored_count) && $stable(lost_count) && $stable(record_done))
		else $error("stalled result changed");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> record_done == (delimiter_found || end_seen))
		else $error("record_done without a cause");

	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_seen |-> !stored && byte_out == 8'd0 && !delimiter_found)
		else $error("end-of-input result carries a byte");

	a_stored_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stored |-> stored_count != '0)
		else $error("stored byte with zero count");

	// every accepted request is followed by out_valid on the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request left no result");

endmodule

bind delimited_record_splitter_top drs_checker u_drs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.byte_out(byte_out),
	.stored(stored),
	.stored_count(stored_count),
	.lost_count(lost_count),
	.delimiter_found(delimiter_found),
	.end_seen(end_seen),
	.record_done(record_done)
);
